// ===== hw/rtl/packed_decimal_float_to_text_macros.svh =====
// Assertion helpers used by the top-level RTL
`ifndef PACKED_DECIMAL_FLOAT_TO_TEXT_MACROS_SVH
`define PACKED_DECIMAL_FLOAT_TO_TEXT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PDFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdft: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define PDFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdft: next-cycle check failed");

`endif

// ===== hw/rtl/pdft_pkg.sv =====
`default_nettype none
package pdft_pkg;

	localparam int VAL_W  = 25;
	localparam int NDIG   = 8;
	localparam int CNT_W  = $clog2(VAL_W);
	localparam int SEL_W  = 3;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_NONE  = 8'h00;

	typedef logic [NDIG-1:0][3:0] pdft_bcd_t;

	// format fields of one word, held while the digits are converted
	typedef struct packed {
		logic             neg;
		logic [SEL_W-1:0] count_m1;
		logic [SEL_W-1:0] point_m1;
	} pdft_fmt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} pdft_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/packed_decimal_float_to_text.sv =====
// Flow: a taken word goes through a 25-step bit-serial BCD conversion; then the
// characters follow one per cycle, two to ten in all, or a single error character.
// A new word is taken only from idle, once the last character has left; busy is
// high from the start of the conversion through the last character.
// The receiver cannot stall: each character is valid for the one strobe cycle.
// Reset (arst_n low, asynchronous) returns the block to idle with no output.
`default_nettype none
`include "packed_decimal_float_to_text_macros.svh"
module packed_decimal_float_to_text
	import pdft_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] encoded_word,
	output logic             busy,
	output logic             strobe,
	output logic [7:0]       char_code,
	output logic             last_char,
	output logic             malformed
);

	pdft_state_t state_q;
	pdft_state_t state_nxt;
	pdft_fmt_t   fmt_q;
	pdft_bcd_t   bcd;
	logic        accept;
	logic        dab_done;
	logic        emit_go;
	logic        emit_fin;

	// take a word only from idle
	assign accept = start && (state_q == ST_IDLE);

	// hold the sign, count and point fields while the digits are converted
	always_ff @(posedge clk) begin
		if (accept) begin
			fmt_q.neg      <= encoded_word[31];
			fmt_q.count_m1 <= encoded_word[5:3];
			fmt_q.point_m1 <= encoded_word[2:0];
		end
	end

	// advance: idle -> convert -> emit -> idle
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (start)    state_nxt = ST_CONV;
			ST_CONV: if (dab_done) state_nxt = ST_EMIT;
			ST_EMIT: if (emit_fin) state_nxt = ST_IDLE;
			default:               state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		emit_go = 1'b0;
		unique case (state_q)
			ST_IDLE: busy    = 1'b0;
			ST_CONV: emit_go = dab_done;
			ST_EMIT: busy    = 1'b1;
			default: busy    = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// shift the digit value in one bit per cycle, building eight BCD digits
	pdft_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.value  (encoded_word[30:6]),
		.done   (dab_done),
		.bcd    (bcd)
	);

	// check the word, then drop out sign, digits and point one per cycle
	pdft_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (emit_go),
		.fmt       (fmt_q),
		.bcd       (bcd),
		.strobe    (strobe),
		.char_code (char_code),
		.last_char (last_char),
		.malformed (malformed),
		.fin       (emit_fin)
	);

	`PDFT_ASSERT_NOW(a_strobe_in_emit, clk, arst_n, strobe, state_q == ST_EMIT)
	`PDFT_ASSERT_NOW(a_bad_is_single, clk, arst_n, strobe && malformed, last_char && (char_code == CH_NONE))
	`PDFT_ASSERT_NEXT(a_last_frees, clk, arst_n, strobe && last_char, !busy && !strobe)
	`PDFT_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !strobe)

endmodule
`default_nettype wire

// ===== hw/rtl/pdft_dabble.sv =====
`default_nettype none
// Bit-serial binary to BCD conversion: one value bit enters per cycle
module pdft_dabble
	import pdft_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic [VAL_W-1:0] value,
	output logic                  done,
	output pdft_bcd_t             bcd
);

	logic [VAL_W-1:0] sh_q;
	pdft_bcd_t        bcd_q;
	pdft_bcd_t        adj;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	// correct each digit that would pass nine once doubled
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(VAL_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= value;
			bcd_q <= '0;
		end else if (run_q) begin
			bcd_q <= pdft_bcd_t'({adj[NDIG-1][2:0], adj[NDIG-2:0], sh_q[VAL_W-1]});
			sh_q  <= {sh_q[VAL_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pdft_emit.sv =====
`default_nettype none
// Character sequencer: one character per cycle from the converted digits
module pdft_emit
	import pdft_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire pdft_fmt_t  fmt,
	input  wire pdft_bcd_t  bcd,
	output logic            strobe,
	output logic [7:0]      char_code,
	output logic            last_char,
	output logic            malformed,
	output logic            fin
);

	logic             active_q;
	logic             bad_q;
	logic             neg_q;
	logic             dot_done_q;
	logic [SEL_W-1:0] idx_q;
	logic [SEL_W-1:0] point_q;
	pdft_bcd_t        bcd_q;
	logic             over;
	logic             bad;
	logic [3:0]       digit;
	logic             put_dot;

	// value needs more digits than the count allows
	always_comb begin
		over = 1'b0;
		for (int i = 0; i < NDIG; i++) begin
			if ((SEL_W'(i) > fmt.count_m1) && (bcd[i] != 4'd0)) begin
				over = 1'b1;
			end
		end
	end

	assign bad     = over || (fmt.point_m1 > fmt.count_m1);
	assign digit   = bcd_q[idx_q];
	assign put_dot = !dot_done_q && (idx_q == point_q);

	always_comb begin
		char_code = CH_NONE;
		last_char = 1'b0;
		malformed = 1'b0;
		if (bad_q) begin
			last_char = 1'b1;
			malformed = 1'b1;
		end else if (neg_q) begin
			char_code = CH_MINUS;
		end else if (put_dot) begin
			char_code = CH_DOT;
		end else begin
			char_code = CH_ZERO + {4'd0, digit};
			last_char = (idx_q == '0);
		end
	end

	assign strobe = active_q;
	assign fin    = active_q && last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (go) begin
			active_q <= 1'b1;
		end else if (fin) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			bad_q      <= bad;
			neg_q      <= fmt.neg;
			dot_done_q <= 1'b0;
			idx_q      <= fmt.count_m1;
			point_q    <= fmt.point_m1;
			bcd_q      <= bcd;
		end else if (active_q && !bad_q) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else if (put_dot) begin
				dot_done_q <= 1'b1;
			end else if (idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire
